>>> rtl/core/zfd_pkg.sv
package zfd_pkg;

  localparam int ByteW = 8;
  localparam int KindW = 2;
  localparam int TypeW = 3;
  localparam int SubsysW = 5;
  localparam int CfgIdxW = 2;

  // Payload length ceiling, whatever max_payload says
  localparam logic [ByteW-1:0] HardMaxPayload = 8'd250;

  localparam logic [ByteW-1:0] StartByteRst = 8'd254;
  localparam logic [ByteW-1:0] MaxPayloadRst = 8'd250;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd1;

  // Event kinds
  localparam logic [KindW-1:0] EV_HEADER = 2'd0;
  localparam logic [KindW-1:0] EV_DATA = 2'd1;
  localparam logic [KindW-1:0] EV_END = 2'd2;
  localparam logic [KindW-1:0] EV_LENERR = 2'd3;

  typedef struct packed {
    logic [KindW-1:0]   event_kind;
    logic [TypeW-1:0]   frame_type;
    logic [SubsysW-1:0] subsystem;
    logic [ByteW-1:0]   command_id;
    logic [ByteW-1:0]   payload_len;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   byte_index;
    logic               status;
  } zfd_event_t;

endpackage

>>> rtl/core/znp_frame_deframer_core.sv
// Streaming deframer for serial frames laid out as start, length, cmd0, cmd1,
// payload[length], check. One byte word enters per cycle on the in_ channel,
// and each byte is fully handled in that cycle: while hunting, bytes other
// than the configured start byte are dropped; after cmd1 a header word is
// produced (type, subsystem, command id, length), then one word per payload
// byte with its index, then a frame end word whose status flags a check byte
// that differs from the XOR of length, cmd0, cmd1 and payload. A length above
// min(max_payload, 250) gives a length error word and a return to hunting. A
// start byte inside a frame is plain data. Throughput is one byte per cycle;
// the result word of an accepted byte is valid in the next cycle, held by the
// single output register. in_ready drops only while that register holds a
// word that out_ready does not take. Write configuration only while idle;
// cfg_ready is always high and writes to unknown indexes are ignored.
module znp_frame_deframer_core
  import zfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ByteW-1:0]    in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KindW-1:0]    out_event_kind,
  output logic [TypeW-1:0]    out_frame_type,
  output logic [SubsysW-1:0]  out_subsystem,
  output logic [ByteW-1:0]    out_command_id,
  output logic [ByteW-1:0]    out_payload_len,
  output logic [ByteW-1:0]    out_data_byte,
  output logic [ByteW-1:0]    out_byte_index,
  output logic                out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [ByteW-1:0]    cfg_data
);

  logic [ByteW-1:0] start_byte_r;
  logic [ByteW-1:0] max_payload_r;
  logic             byte_fire;
  logic             ev_valid;
  zfd_event_t       ev;
  zfd_event_t       out_ev;

  assign cfg_ready = 1'b1;
  assign byte_fire = in_valid && in_ready;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= StartByteRst;
      max_payload_r <= MaxPayloadRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_BYTE:  start_byte_r  <= cfg_data;
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame state machine: decode the byte, advance on accept
  zfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (byte_fire),
    .rx_byte     (in_rx_byte),
    .start_byte  (start_byte_r),
    .max_payload (max_payload_r),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  // result register: hold the event word until the sink takes it
  zfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (byte_fire && ev_valid),
    .ev        (ev),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .up_ready  (in_ready),
    .out_ev    (out_ev)
  );

  assign out_event_kind  = out_ev.event_kind;
  assign out_frame_type  = out_ev.frame_type;
  assign out_subsystem   = out_ev.subsystem;
  assign out_command_id  = out_ev.command_id;
  assign out_payload_len = out_ev.payload_len;
  assign out_data_byte   = out_ev.data_byte;
  assign out_byte_index  = out_ev.byte_index;
  assign out_status      = out_ev.status;

endmodule

>>> rtl/core/zfd_parser.sv
module zfd_parser
  import zfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_fire,
  input  logic [ByteW-1:0] rx_byte,
  input  logic [ByteW-1:0] start_byte,
  input  logic [ByteW-1:0] max_payload,
  output logic             ev_valid,
  output zfd_event_t       ev
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_CMD0    = 3'd2;
  localparam logic [2:0] PH_CMD1    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CHECK   = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic [ByteW-1:0] xor_r, xor_nxt;
  logic [ByteW-1:0] frame_length_r, frame_length_nxt;
  logic [ByteW-1:0] payload_count_r, payload_count_nxt;
  logic [ByteW-1:0] cmd0_r, cmd0_nxt;
  logic [ByteW-1:0] limit;
  logic [ByteW-1:0] count_inc;

  assign limit = (max_payload < HardMaxPayload) ? max_payload : HardMaxPayload;
  assign count_inc = payload_count_r + 8'd1;

  always_comb begin
    phase_nxt         = phase_r;
    xor_nxt           = xor_r;
    frame_length_nxt  = frame_length_r;
    payload_count_nxt = payload_count_r;
    cmd0_nxt          = cmd0_r;
    ev_valid          = 1'b0;
    ev                = '0;
    case (phase_r)
      PH_LEN: begin
        if (rx_byte > limit) begin
          ev_valid       = 1'b1;
          ev.event_kind  = EV_LENERR;
          ev.payload_len = rx_byte;
          phase_nxt      = PH_HUNT;
        end else begin
          frame_length_nxt = rx_byte;
          xor_nxt          = rx_byte;
          phase_nxt        = PH_CMD0;
        end
      end
      PH_CMD0: begin
        cmd0_nxt  = rx_byte;
        xor_nxt   = xor_r ^ rx_byte;
        phase_nxt = PH_CMD1;
      end
      PH_CMD1: begin
        xor_nxt           = xor_r ^ rx_byte;
        payload_count_nxt = '0;
        ev_valid          = 1'b1;
        ev.event_kind     = EV_HEADER;
        ev.frame_type     = cmd0_r[7:5];
        ev.subsystem      = cmd0_r[4:0];
        ev.command_id     = rx_byte;
        ev.payload_len    = frame_length_r;
        phase_nxt         = (frame_length_r == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        xor_nxt           = xor_r ^ rx_byte;
        ev_valid          = 1'b1;
        ev.event_kind     = EV_DATA;
        ev.data_byte      = rx_byte;
        ev.byte_index     = payload_count_r;
        payload_count_nxt = count_inc;
        if (count_inc >= frame_length_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        ev_valid      = 1'b1;
        ev.event_kind = EV_END;
        ev.status     = (xor_r != rx_byte);
        phase_nxt     = PH_HUNT;
      end
      default: begin
        // hunting: drop everything but the start byte
        if (rx_byte == start_byte) begin
          xor_nxt   = '0;
          phase_nxt = PH_LEN;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      xor_r           <= '0;
      frame_length_r  <= '0;
      payload_count_r <= '0;
      cmd0_r          <= '0;
    end else if (byte_fire) begin
      phase_r         <= phase_nxt;
      xor_r           <= xor_nxt;
      frame_length_r  <= frame_length_nxt;
      payload_count_r <= payload_count_nxt;
      cmd0_r          <= cmd0_nxt;
    end
  end

`ifndef SYNTHESIS
  a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (frame_length_r != '0))
    else $error("payload phase with zero frame length");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (payload_count_r < frame_length_r))
    else $error("payload count ran past frame length");

  a_length_capped: assert property (@(posedge clk) disable iff (!rst_n)
    frame_length_r <= HardMaxPayload)
    else $error("stored frame length above hard maximum");

  a_lenerr_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_fire && ev_valid && ev.event_kind == EV_LENERR) |=> (phase_r == PH_HUNT))
    else $error("length error did not return to hunting");
`endif

endmodule

>>> rtl/core/zfd_out_reg.sv
module zfd_out_reg
  import zfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  zfd_event_t ev,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       up_ready,
  output zfd_event_t out_ev
);

  logic       valid_r, valid_nxt;
  zfd_event_t ev_r;

  // take a new word whenever the held one is empty or leaving this cycle
  assign up_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r <= ev;
    end
  end

  assign out_valid = valid_r;
  assign out_ev    = ev_r;

endmodule

>>> tb/zfd_event_checker.sv
module zfd_event_checker
  import zfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [ByteW-1:0]   in_rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [KindW-1:0]   out_event_kind,
  input  logic [TypeW-1:0]   out_frame_type,
  input  logic [SubsysW-1:0] out_subsystem,
  input  logic [ByteW-1:0]   out_command_id,
  input  logic [ByteW-1:0]   out_payload_len,
  input  logic [ByteW-1:0]   out_data_byte,
  input  logic [ByteW-1:0]   out_byte_index,
  input  logic               out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 words_checked,
  output logic               hunting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_CMD0, PH_CMD1, PH_PAYLOAD, PH_CHECK
  } parse_phase_e;

  parse_phase_e     phase;
  logic [ByteW-1:0] start_byte;
  logic [ByteW-1:0] max_payload;
  logic [ByteW-1:0] running_xor;
  logic [ByteW-1:0] frame_length;
  logic [ByteW-1:0] payload_count;
  logic [ByteW-1:0] held_cmd0;

  zfd_event_t expected_events[$];

  // Advance the frame parser by one byte; return 1 when the byte yields an event.
  function automatic bit deframe_byte(input logic [ByteW-1:0] b, output zfd_event_t ev);
    logic [ByteW-1:0] limit;
    bit               emits;
    limit = (max_payload < HardMaxPayload) ? max_payload : HardMaxPayload;
    ev = '0;
    emits = 1'b0;
    case (phase)
      PH_LEN: begin
        if (b > limit) begin
          ev.event_kind = EV_LENERR;
          ev.payload_len = b;
          phase = PH_HUNT;
          emits = 1'b1;
        end else begin
          frame_length = b;
          running_xor = b;
          phase = PH_CMD0;
        end
      end
      PH_CMD0: begin
        held_cmd0 = b;
        running_xor = running_xor ^ b;
        phase = PH_CMD1;
      end
      PH_CMD1: begin
        running_xor = running_xor ^ b;
        payload_count = '0;
        ev.event_kind = EV_HEADER;
        ev.frame_type = held_cmd0[ByteW-1 -: TypeW];
        ev.subsystem = held_cmd0[SubsysW-1:0];
        ev.command_id = b;
        ev.payload_len = frame_length;
        phase = (frame_length == '0) ? PH_CHECK : PH_PAYLOAD;
        emits = 1'b1;
      end
      PH_PAYLOAD: begin
        running_xor = running_xor ^ b;
        ev.event_kind = EV_DATA;
        ev.data_byte = b;
        ev.byte_index = payload_count;
        payload_count = payload_count + 8'd1;
        if (payload_count >= frame_length) phase = PH_CHECK;
        emits = 1'b1;
      end
      PH_CHECK: begin
        ev.event_kind = EV_END;
        ev.status = (running_xor != b);
        phase = PH_HUNT;
        emits = 1'b1;
      end
      default: begin
        if (b == start_byte) begin
          running_xor = '0;
          phase = PH_LEN;
        end else begin
          phase = PH_HUNT;
        end
      end
    endcase
    return emits;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns deframer: %s", $realtime, msg);
  endtask

  task automatic compare_event(input zfd_event_t got, input zfd_event_t want);
    if (got.event_kind !== want.event_kind)
      report_mismatch($sformatf("event_kind %0d, expected %0d", got.event_kind,
                                want.event_kind));
    if (got.frame_type !== want.frame_type)
      report_mismatch($sformatf("frame_type %0d, expected %0d", got.frame_type,
                                want.frame_type));
    if (got.subsystem !== want.subsystem)
      report_mismatch($sformatf("subsystem %0d, expected %0d", got.subsystem,
                                want.subsystem));
    if (got.command_id !== want.command_id)
      report_mismatch($sformatf("command_id 0x%h, expected 0x%h", got.command_id,
                                want.command_id));
    if (got.payload_len !== want.payload_len)
      report_mismatch($sformatf("payload_len %0d, expected %0d", got.payload_len,
                                want.payload_len));
    if (got.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte 0x%h, expected 0x%h", got.data_byte,
                                want.data_byte));
    if (got.byte_index !== want.byte_index)
      report_mismatch($sformatf("byte_index %0d, expected %0d", got.byte_index,
                                want.byte_index));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
  endtask

  always @(posedge clk) begin : watch
    zfd_event_t got;
    zfd_event_t want;
    zfd_event_t ev;
    if (!rst_n) begin
      phase = PH_HUNT;
      start_byte = StartByteRst;
      max_payload = MaxPayloadRst;
      running_xor = '0;
      frame_length = '0;
      payload_count = '0;
      held_cmd0 = '0;
      expected_events.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      // Retire the result word first: it always stems from an earlier byte.
      if (out_valid && out_ready) begin
        got.event_kind = out_event_kind;
        got.frame_type = out_frame_type;
        got.subsystem = out_subsystem;
        got.command_id = out_command_id;
        got.payload_len = out_payload_len;
        got.data_byte = out_data_byte;
        got.byte_index = out_byte_index;
        got.status = out_status;
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected word of kind %0d", out_event_kind));
        end else begin
          want = expected_events.pop_front();
          compare_event(got, want);
          words_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_BYTE:  start_byte = cfg_data;
          CFG_MAX_PAYLOAD: max_payload = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(in_rx_byte, ev)) expected_events.push_back(ev);
      end
    end
    pending = expected_events.size();
    hunting = (phase == PH_HUNT);
  end

endmodule

>>> tb/znp_frame_deframer_core_test.sv
module znp_frame_deframer_core_test
  import zfd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes the block decodes to nothing; writes there must leave it untouched
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ByteW-1:0]   in_rx_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [KindW-1:0]   out_event_kind;
  logic [TypeW-1:0]   out_frame_type;
  logic [SubsysW-1:0] out_subsystem;
  logic [ByteW-1:0]   out_command_id;
  logic [ByteW-1:0]   out_payload_len;
  logic [ByteW-1:0]   out_data_byte;
  logic [ByteW-1:0]   out_byte_index;
  logic               out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;

  int   fail_count;
  int   pending;
  int   words_checked;
  logic hunting;

  // Stimulus bookkeeping: what the sender believes is configured, and tallies
  logic [ByteW-1:0] cur_start = StartByteRst;
  int               cur_limit = int'(MaxPayloadRst);
  int               bytes_sent = 0;
  int               frames_sent = 0;
  int               len_errors_sent = 0;
  int               settings_applied = 0;
  int               pauses = 0;

  // Calm stretches: while set, the side concerned never idles
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  znp_frame_deframer_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_frame_type (out_frame_type),
    .out_subsystem  (out_subsystem),
    .out_command_id (out_command_id),
    .out_payload_len(out_payload_len),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  zfd_event_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_frame_type (out_frame_type),
    .out_subsystem  (out_subsystem),
    .out_command_id (out_command_id),
    .out_payload_len(out_payload_len),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .words_checked  (words_checked),
    .hunting        (hunting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Flip the calm flags now and then so idle-free runs of varying length occur
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) in_calm <= !in_calm;
    if ($urandom_range(0, 63) == 0) out_calm <= !out_calm;
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Send one byte word. Valid stays high after acceptance so that a zero gap
  // presents the next word on the very next edge; drop it only when idling.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Present one register write; valid is left high for back-to-back writes.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write both registers plus both spare indexes, then release the channel.
  task automatic apply_settings(input logic [ByteW-1:0] start,
                                input logic [ByteW-1:0] maxp);
    write_reg(CFG_START_BYTE, start);
    write_reg(CFG_MAX_PAYLOAD, maxp);
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_SPARE_HI, 8'($urandom));
    cfg_valid <= 1'b0;
    cur_start = start;
    cur_limit = int'((maxp < HardMaxPayload) ? maxp : HardMaxPayload);
    settings_applied++;
  endtask

  // Hold until every predicted word has come out. Sample on the falling edge
  // so the checker has already booked anything accepted at the last rise.
  task automatic await_results();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Bring the block back to hunting with nothing in flight, so that a
  // register write cannot land in the middle of a frame.
  task automatic settle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (hunting) break;
      // Mid-frame: feed filler until the frame closes (zero is never a bad length)
      @(posedge clk);
      send_byte('0);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    await_results();
    // Let the block idle before returning
    repeat (4) @(posedge clk);
  endtask

  // One well-formed frame with random command bytes and payload; a corrupt
  // frame gets one bit of its check byte flipped.
  task automatic send_frame(input int len, input bit corrupt);
    logic [ByteW-1:0] cmd0;
    logic [ByteW-1:0] cmd1;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] fcs;
    cmd0 = 8'($urandom);
    cmd1 = 8'($urandom);
    fcs = 8'(len) ^ cmd0 ^ cmd1;
    send_byte(cur_start);
    send_byte(8'(len));
    send_byte(cmd0);
    send_byte(cmd1);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      fcs = fcs ^ b;
      send_byte(b);
    end
    if (corrupt) fcs = fcs ^ 8'(1 << $urandom_range(0, 7));
    send_byte(fcs);
    frames_sent++;
  endtask

  // Mostly well-formed frames with random content; the rest is length errors
  // and line noise between frames.
  task automatic run_random(input int budget);
    int               stop_at;
    int               pick;
    int               len;
    logic [ByteW-1:0] b;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        len = $urandom_range(0, (cur_limit < 8) ? cur_limit : 8);
        // Hit the exact limit often when it is cheap to do so
        if (cur_limit <= 20 && $urandom_range(0, 3) == 0) len = cur_limit;
        send_frame(len, $urandom_range(0, 7) == 0);
      end else if (pick < 17) begin
        send_byte(cur_start);
        send_byte(8'($urandom_range(cur_limit + 1, 255)));
        len_errors_sent++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          // Keep noise off the start byte so frames stay aligned
          do b = 8'($urandom); while (b == cur_start);
          send_byte(b);
        end
      end
      if ($urandom_range(0, 24) == 0) begin
        in_valid <= 1'b0;
        await_results();
        pauses++;
      end
    end
  endtask

  // Sink: draw a stall for every result word, then take it.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: start byte 0xFE, limit 250.
    // Drop noise while hunting, extremes of the byte included.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFD);
    // Two-byte payload that carries the start byte as plain data; cmd0 all
    // ones gives the top type and subsystem; check byte is correct.
    send_byte(8'hFE);
    send_byte(8'h02);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'h00);
    send_byte(8'h03);
    frames_sent++;
    // Stop feeding until the block has delivered everything so far
    in_valid <= 1'b0;
    await_results();
    pauses++;
    // Empty payload straight into the check byte, which is wrong
    send_byte(8'hFE);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    frames_sent++;
    // Lengths just above the ceiling and at the top of the byte range
    send_byte(8'hFE);
    send_byte(8'd251);
    send_byte(8'hFE);
    send_byte(8'hFF);
    len_errors_sent += 2;

    // Lowest settings: start byte zero, only empty payloads accepted
    settle();
    apply_settings(8'h00, 8'h00);
    run_random(60);

    // Highest settings: the limit clamps to 250; send one full-size frame
    settle();
    apply_settings(8'hFF, 8'hFF);
    send_frame(int'(HardMaxPayload), 1'b0);
    run_random(40);

    // Arbitrary start byte with a small limit
    settle();
    apply_settings(8'($urandom), 8'($urandom_range(1, 20)));
    run_random(70);

    settle();
    $display("Sent %0d bytes: %0d frames, %0d length errors, %0d register settings",
             bytes_sent, frames_sent, len_errors_sent, settings_applied + 1);
    $display("Checked %0d event words, %0d full drains mid-stream", words_checked, pauses);
    if (fail_count == 0) begin
      $display("PASS znp_frame_deframer_core");
    end else begin
      $display("FAIL znp_frame_deframer_core");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Timed out with %0d words outstanding", pending);
    $display("FAIL znp_frame_deframer_core");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/zfd_pkg.sv
rtl/core/zfd_parser.sv
rtl/core/zfd_out_reg.sv
rtl/core/znp_frame_deframer_core.sv
tb/zfd_event_checker.sv
tb/znp_frame_deframer_core_test.sv
